// File: src/tun_pkg.sv
// Shared widths, stage counts and the normalize-stage record for the unit-normal block.
package tun_pkg;

  localparam int CW   = 16;            // vertex coordinate width, signed Q8.8
  localparam int FB   = 14;            // fraction bits of the normal components
  localparam int EW   = CW + 1;        // edge vector component
  localparam int PW   = 2 * EW;        // one product of the cross product
  localparam int NW   = PW + 1;        // signed cross product component
  localparam int MW   = NW - 1;        // cross product magnitude
  localparam int HW   = MW / 2;        // low half for the split squaring
  localparam int HIW  = MW - HW;       // high half for the split squaring
  localparam int SQW  = 2 * MW;        // square of one component
  localparam int SW   = SQW + 2;       // sum of three squares
  localparam int RW   = SW + 2 * FB + 5; // normalize recurrence, signed
  localparam int QW   = FB + 1;        // result magnitude
  localparam int OW   = FB + 2;        // signed result
  localparam int PRE  = 7;             // stages ahead of the normalize chain
  localparam int NSTG = PRE + QW + 1;  // total register stages
  localparam int NORM_ONE = 2 ** FB;

  typedef struct packed {
    logic signed [RW-1:0] r;   // remainder against the target
    logic signed [RW-1:0] a;   // scaled s*(2q-1) term
    logic signed [RW-1:0] b;   // scaled s term
    logic [QW-1:0]        q;   // result bits so far, MSB first
    logic                 neg;
    logic                 degen;
  } tun_norm_t;

endpackage

// File: src/tun_norm_step.sv
// One registered step of the bit-at-a-time normalize recurrence.
module tun_norm_step (
  input  logic               clk_i,
  input  logic               en_i,
  input  tun_pkg::tun_norm_t st_i,
  output tun_pkg::tun_norm_t st_o
);

  logic signed [tun_pkg::RW-1:0] r, a, b, delta, diff;
  logic                          take;
  tun_pkg::tun_norm_t            st_d, st_q;

  always_comb begin
    r     = st_i.r;
    a     = st_i.a;
    b     = st_i.b;
    delta = a + b;
    diff  = r - delta;
    take  = !diff[tun_pkg::RW-1];
    st_d       = st_i;
    st_d.r     = take ? diff : r;
    st_d.a     = take ? ((a >>> 1) + b) : (a >>> 1);
    st_d.b     = b >>> 2;
    st_d.q     = {st_i.q[tun_pkg::QW-2:0], take};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

endmodule

// File: src/triangle_unit_normal.sv
// Top level: unit face normal of one triangle per request, fully pipelined.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------
//   input    | in_valid_i / in_stall_o   | ax..cz (signed Q8.8)
//   output   | out_valid_o / out_stall_i | nx ny nz (Q1.14), degenerate
//
// One request enters per cycle while the output is not stalled. The pipeline
// has 7 stages of edges, cross product, split squaring and setup, then one
// stage per result bit of the normalize recurrence (15), then the output
// register. Reset clears only the valid bits. A stall at the output freezes
// every stage at once, so nothing is lost or repeated.
module triangle_unit_normal (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [tun_pkg::CW-1:0] ax_i,
  input  logic signed [tun_pkg::CW-1:0] ay_i,
  input  logic signed [tun_pkg::CW-1:0] az_i,
  input  logic signed [tun_pkg::CW-1:0] bx_i,
  input  logic signed [tun_pkg::CW-1:0] by_i,
  input  logic signed [tun_pkg::CW-1:0] bz_i,
  input  logic signed [tun_pkg::CW-1:0] cx_i,
  input  logic signed [tun_pkg::CW-1:0] cy_i,
  input  logic signed [tun_pkg::CW-1:0] cz_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [tun_pkg::OW-1:0] nx_o,
  output logic signed [tun_pkg::OW-1:0] ny_o,
  output logic signed [tun_pkg::OW-1:0] nz_o,
  output logic                         degenerate_o
);

  localparam int CW = tun_pkg::CW;
  localparam int EW = tun_pkg::EW;
  localparam int PW = tun_pkg::PW;
  localparam int NW = tun_pkg::NW;
  localparam int MW = tun_pkg::MW;
  localparam int HW = tun_pkg::HW;
  localparam int HIW = tun_pkg::HIW;
  localparam int SQW = tun_pkg::SQW;
  localparam int SW = tun_pkg::SW;
  localparam int RW = tun_pkg::RW;
  localparam int QW = tun_pkg::QW;
  localparam int OW = tun_pkg::OW;
  localparam int FB = tun_pkg::FB;
  localparam int NSTG = tun_pkg::NSTG;

  logic                  en;
  logic [NSTG-1:0]       v_q;

  assign en          = !(v_q[NSTG-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = v_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  // stage 1: edges
  logic signed [EW-1:0] e_d [6];
  logic signed [EW-1:0] e_q [6];
  always_comb begin
    e_d[0] = {bx_i[CW-1], bx_i} - {ax_i[CW-1], ax_i};
    e_d[1] = {by_i[CW-1], by_i} - {ay_i[CW-1], ay_i};
    e_d[2] = {bz_i[CW-1], bz_i} - {az_i[CW-1], az_i};
    e_d[3] = {cx_i[CW-1], cx_i} - {ax_i[CW-1], ax_i};
    e_d[4] = {cy_i[CW-1], cy_i} - {ay_i[CW-1], ay_i};
    e_d[5] = {cz_i[CW-1], cz_i} - {az_i[CW-1], az_i};
  end

  // stage 2: the six cross products
  logic signed [PW-1:0] p_q [6];

  // stage 3: components as sign and magnitude
  logic signed [NW-1:0] c_d [3];
  logic signed [NW-1:0] cabs [3];
  logic [MW-1:0]        mag_q [3];
  logic                 neg3_q [3];

  // stage 4: partial products of the squares
  logic [2*HIW-1:0]     hh_q [3];
  logic [HIW+HW-1:0]    hl_q [3];
  logic [2*HW-1:0]      ll_q [3];
  logic                 neg4_q [3];

  // stage 5: squares
  logic [SQW-1:0]       sq_d [3];
  logic [SQW-1:0]       sq_q [3];
  logic                 neg5_q [3];

  // stage 6: sum of squares
  logic [SW-1:0]        s_q;
  logic [SQW-1:0]       sq6_q [3];
  logic                 neg6_q [3];

  // stage 7 and the normalize chain
  tun_pkg::tun_norm_t   ns [QW+1][3];
  tun_pkg::tun_norm_t   init_d [3];
  tun_pkg::tun_norm_t   init_q [3];
  logic signed [RW-1:0] sx;
  logic signed [RW-1:0] sqx [3];

  always_comb begin
    c_d[0] = {p_q[0][PW-1], p_q[0]} - {p_q[1][PW-1], p_q[1]};
    c_d[1] = {p_q[2][PW-1], p_q[2]} - {p_q[3][PW-1], p_q[3]};
    c_d[2] = {p_q[4][PW-1], p_q[4]} - {p_q[5][PW-1], p_q[5]};
    for (int i = 0; i < 3; i++) begin
      cabs[i] = c_d[i][NW-1] ? -c_d[i] : c_d[i];
      sq_d[i] = ({{(SQW-2*HIW){1'b0}}, hh_q[i]} << (2*HW))
              + ({{(SQW-HIW-HW){1'b0}}, hl_q[i]} << (HW+1))
              + {{(SQW-2*HW){1'b0}}, ll_q[i]};
    end
    sx = {{(RW-SW){1'b0}}, s_q};
    for (int i = 0; i < 3; i++) begin
      sqx[i]          = {{(RW-SQW){1'b0}}, sq6_q[i]};
      init_d[i].r     = (sqx[i] <<< (2*FB+2)) - sx;
      init_d[i].a     = -(sx <<< (FB+2));
      init_d[i].b     = sx <<< (2*FB+2);
      init_d[i].q     = '0;
      init_d[i].neg   = neg6_q[i];
      init_d[i].degen = (s_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q    <= e_d;
      p_q[0] <= e_q[1] * e_q[5];
      p_q[1] <= e_q[2] * e_q[4];
      p_q[2] <= e_q[2] * e_q[3];
      p_q[3] <= e_q[0] * e_q[5];
      p_q[4] <= e_q[0] * e_q[4];
      p_q[5] <= e_q[1] * e_q[3];
      for (int i = 0; i < 3; i++) begin
        mag_q[i]  <= cabs[i][MW-1:0];
        neg3_q[i] <= c_d[i][NW-1];
        hh_q[i]   <= mag_q[i][MW-1:HW] * mag_q[i][MW-1:HW];
        hl_q[i]   <= mag_q[i][MW-1:HW] * mag_q[i][HW-1:0];
        ll_q[i]   <= mag_q[i][HW-1:0] * mag_q[i][HW-1:0];
        neg4_q[i] <= neg3_q[i];
        sq_q[i]   <= sq_d[i];
        neg5_q[i] <= neg4_q[i];
        sq6_q[i]  <= sq_q[i];
        neg6_q[i] <= neg5_q[i];
        init_q[i] <= init_d[i];
      end
      s_q <= {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_init
    assign ns[0][i] = init_q[i];
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    for (genvar i = 0; i < 3; i++) begin : g_comp
      tun_norm_step u_step (
        .clk_i (clk_i),
        .en_i  (en),
        .st_i  (ns[j][i]),
        .st_o  (ns[j+1][i])
      );
    end
  end

  // output register: apply sign, force zero on a degenerate triangle
  logic signed [OW-1:0] n_d [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ns[QW][i].degen) begin
        n_d[i] = '0;
      end else if (ns[QW][i].neg) begin
        n_d[i] = -{1'b0, ns[QW][i].q};
      end else begin
        n_d[i] = {1'b0, ns[QW][i].q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_o         <= n_d[0];
      ny_o         <= n_d[1];
      nz_o         <= n_d[2];
      degenerate_o <= ns[QW][0].degen;
    end
  end

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |-> (nx_o == '0 && ny_o == '0 && nz_o == '0))
    else $error("degenerate result with nonzero normal");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (nx_o <= tun_pkg::NORM_ONE && nx_o >= -tun_pkg::NORM_ONE &&
                     ny_o <= tun_pkg::NORM_ONE && ny_o >= -tun_pkg::NORM_ONE &&
                     nz_o <= tun_pkg::NORM_ONE && nz_o >= -tun_pkg::NORM_ONE))
    else $error("normal component out of range");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(v_q))
    else $error("pipeline moved during a stall");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked output");

endmodule
